// ===== sv/aes128_pkg.sv =====
package aes128_pkg;

  typedef struct packed {
    logic [63:0] plain_first;
    logic [63:0] plain_second;
  } in_beat_t;

  typedef struct packed {
    logic [63:0] cipher_first;
    logic [63:0] cipher_second;
  } out_beat_t;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] RegKeyFirst = 1'b0;
  localparam logic [CfgIdxW-1:0] RegKeySecond = 1'b1;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [NumRounds] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  function automatic logic [7:0] xtime(input logic [7:0] v);
    xtime = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of the state sits at bits 127-8i
  function automatic logic [7:0] get_byte(input logic [127:0] s, input int i);
    get_byte = s[127-8*i -: 8];
  endfunction

  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127-8*(r+4*c) -: 8] = SBOX[get_byte(s, r + 4*((c + r) % 4))];
      end
    end
    sub_shift = t;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3, all;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, 4*c);
      a1 = get_byte(s, 4*c+1);
      a2 = get_byte(s, 4*c+2);
      a3 = get_byte(s, 4*c+3);
      all = a0 ^ a1 ^ a2 ^ a3;
      t[127-8*(4*c)   -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
      t[127-8*(4*c+1) -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
      t[127-8*(4*c+2) -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
      t[127-8*(4*c+3) -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
    end
    mix_columns = t;
  endfunction

  // next round key from the previous one
  function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    t = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    next_key = {w0, w1, w2, w3};
  endfunction

endpackage

// ===== sv/aes128_round.sv =====
module aes128_round
  import aes128_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         advance,
  input  logic         last,
  input  logic [7:0]   rcon,
  input  logic         valid_in,
  input  logic [127:0] state_in,
  input  logic [127:0] key_in,
  output logic         valid_out,
  output logic [127:0] state_out,
  output logic [127:0] key_out
);

  logic [127:0] key_next;
  logic [127:0] mixed;
  logic [127:0] state_next;

  always_comb begin
    key_next   = next_key(key_in, rcon);
    mixed      = sub_shift(state_in);
    if (!last) begin
      mixed = mix_columns(mixed);
    end
    state_next = mixed ^ key_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (advance) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      state_out <= state_next;
      key_out   <= key_next;
    end
  end

endmodule

// ===== sv/aes128_block_encrypt_top.sv =====
// AES-128 encryption pipeline, one 16-byte block per beat.
// Channels: in (in_valid/in_ready/in_data) carries plaintext, out
// (out_valid/out_ready/out_data) carries ciphertext; byte 0 is in the top
// bits of the first half of each struct.
// Key: written through cfg_we/cfg_index/cfg_data, index 0 = key bytes 0..7,
// index 1 = key bytes 8..15. Other indexes are dropped. Write only while idle.
// Structure: whitening stage, then ten round stages; each stage expands its
// own round key alongside the data, so the key schedule is pipelined too.
// Depth: 11 register stages, the whitening stage and the ten round stages.
// Throughput: one block per cycle while not stalled; a round (SubBytes,
// ShiftRows, MixColumns except in the last round, AddRoundKey plus one
// key-schedule step) is the depth between registers.
// Stall: the whole pipe freezes while out_valid is high and out_ready low;
// in_ready then drops only if the output stage holds a beat. Nothing is
// lost or repeated.
// Reset: rst (sync, active high) clears all stage valid bits and the key.
module aes128_block_encrypt_top
  import aes128_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_beat_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_beat_t            out_data,
  input  logic                 cfg_we,
  input  logic [CfgIdxW-1:0]   cfg_index,
  input  logic [63:0]          cfg_data
);

  logic [63:0] key_first;
  logic [63:0] key_second;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_first  <= '0;
      key_second <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegKeyFirst:  key_first  <= cfg_data;
        RegKeySecond: key_second <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipe moves whenever the final stage is empty or being drained
  logic advance;
  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  logic         vld [NumRounds+1];
  logic [127:0] st  [NumRounds+1];
  logic [127:0] rk  [NumRounds+1];

  // stage 0: initial key whitening
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (advance) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      st[0] <= {in_data.plain_first, in_data.plain_second} ^ {key_first, key_second};
      rk[0] <= {key_first, key_second};
    end
  end

  for (genvar g = 0; g < NumRounds; g++) begin : g_round
    aes128_round u_round (
      .clk       (clk),
      .rst       (rst),
      .advance   (advance),
      .last      (g == NumRounds - 1),
      .rcon      (RCON[g]),
      .valid_in  (vld[g]),
      .state_in  (st[g]),
      .key_in    (rk[g]),
      .valid_out (vld[g+1]),
      .state_out (st[g+1]),
      .key_out   (rk[g+1])
    );
  end

  assign out_valid              = vld[NumRounds];
  assign out_data.cipher_first  = st[NumRounds][127:64];
  assign out_data.cipher_second = st[NumRounds][63:0];

endmodule
